FILE: hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_ram users and the top level.
package tcw_pkg;

    // Action codes carried on the command port
    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DONE
    } t_state;

    // Configuration register indexes
    localparam logic REG_ATTR = 1'b0;
    localparam logic REG_PROT = 1'b1;

    // Field widths fixed by the port definition
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COLF_W = 7;
    localparam int ROWF_W = 5;
    localparam int POS_W  = 11;

    // Special characters and blank cell contents
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_BLANK = 8'h07;

    // Reset values of the configuration registers
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
    localparam logic [ROWF_W-1:0] PROT_RESET = 5'd3;

endpackage

FILE: hdl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/text_console_writer.sv
// Text console writer: character/attribute grid with cursor, top level.
// Depends on tcw_pkg and tcw_ram (two instances, character and attribute planes).
//
// A command is taken at a clock edge where start is high and busy is low; the
// result word appears on the o_ ports for exactly one cycle with o_valid high,
// and the receiver cannot stall it. After reset the block sweeps the whole
// grid to blanks, one cell per cycle, with busy high; configuration writes
// are taken throughout.
// Command steps, paced by the single write port of each grid memory:
//   put char (no scroll), set cursor: cursor (and cell) update, then result
//   read cell: registered memory read, then result
//   clear screen: every cell blanked in turn, then result
//   put char that scrolls: row copy moving rows 1 to ROWS_N-1 up by one row,
//   then the last row is blanked, then result
// The result strobe is registered from the final state of each command; busy
// drops in the same cycle as the strobe.
module text_console_writer #(
    parameter int COLUMNS_N = 80,
    parameter int ROWS_N    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::COLF_W-1:0]    i_col,
    input  logic [tcw_pkg::ROWF_W-1:0]    i_row,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic [tcw_pkg::POS_W-1:0]     o_cursor_position,
    output logic [tcw_pkg::CHAR_W-1:0]    o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]    o_cell_attribute,
    output logic                          o_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS_N * ROWS_N;
    localparam int KEEP   = (ROWS_N - 1) * COLUMNS_N;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(COLUMNS_N);
    localparam int ROW_W  = $clog2(ROWS_N);

    // Control state
    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [ATTR_W-1:0]   r_attr;
    logic [ROWF_W-1:0]   r_prot;
    logic [CNT_W-1:0]    r_cnt, n_cnt;      // fill address or copy source
    logic [ADDR_W-1:0]   r_dst, n_dst;      // copy destination, one row above source
    logic                r_pend, n_pend;    // copy write waiting for read data
    logic                r_emit, n_emit;    // fill ends in a result word
    logic                r_scroll, n_scroll;
    logic [ATTR_W-1:0]   r_fill_attr, n_fill_attr;
    logic                r_o_valid, n_o_valid;

    // Result payload
    logic [POS_W-1:0]    r_o_pos, n_o_pos;
    logic [CHAR_W-1:0]   r_o_char, n_o_char;
    logic [ATTR_W-1:0]   r_o_attr, n_o_attr;
    logic                r_o_scr, n_o_scr;

    // Memory ports
    logic                char_we, attr_we;
    logic [ADDR_W-1:0]   char_waddr, attr_waddr, raddr;
    logic [CHAR_W-1:0]   char_wdata, char_rdata;
    logic [ATTR_W-1:0]   attr_wdata, attr_rdata;

    // Decode of the current command
    logic                accept;
    t_action             act;
    logic [COL_W-1:0]    sat_col;
    logic [ROW_W-1:0]    sat_row;
    logic [ADDR_W-1:0]   cur_idx, req_idx, put_idx;
    logic [COL_W-1:0]    put_col;
    logic [ROW_W-1:0]    put_row;
    logic                put_wrap;

    assign accept = start && (r_state == ST_IDLE);
    assign act    = t_action'(i_action);
    assign busy   = (r_state != ST_IDLE);

    // Clamp the requested position to the grid
    assign sat_col = (i_col > COLF_W'(COLUMNS_N - 1)) ? COL_W'(COLUMNS_N - 1)
                                                      : i_col[COL_W-1:0];
    assign sat_row = (i_row > ROWF_W'(ROWS_N - 1)) ? ROW_W'(ROWS_N - 1)
                                                   : i_row[ROW_W-1:0];

    assign cur_idx = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS_N)) + ADDR_W'(r_col);
    assign req_idx = ADDR_W'(ADDR_W'(sat_row) * ADDR_W'(COLUMNS_N)) + ADDR_W'(sat_col);
    assign put_idx = ADDR_W'(ADDR_W'(put_row) * ADDR_W'(COLUMNS_N)) + ADDR_W'(put_col);

    // Cursor movement of a put char; a row step past the last row stays on the
    // last row and flags a scroll.
    always_comb begin
        put_col  = r_col;
        put_row  = r_row;
        put_wrap = 1'b0;
        case (i_char_code)
            CHAR_NL: begin
                put_col = '0;
                if (r_row == ROW_W'(ROWS_N - 1)) begin
                    put_wrap = 1'b1;
                end else begin
                    put_row = r_row + 1'b1;
                end
            end
            CHAR_TAB: begin
            end
            CHAR_BS: begin
                if (r_col != '0) begin
                    put_col = r_col - 1'b1;
                end else if (ROWF_W'(r_row) > r_prot) begin
                    put_row = r_row - 1'b1;
                    put_col = COL_W'(COLUMNS_N - 1);
                end
            end
            default: begin
                if (r_col == COL_W'(COLUMNS_N - 1)) begin
                    put_col = '0;
                    if (r_row == ROW_W'(ROWS_N - 1)) begin
                        put_wrap = 1'b1;
                    end else begin
                        put_row = r_row + 1'b1;
                    end
                end else begin
                    put_col = r_col + 1'b1;
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (act)
                        ACT_PUT:   n_state = put_wrap ? ST_COPY : ST_DONE;
                        ACT_SET:   n_state = ST_DONE;
                        ACT_CLEAR: n_state = ST_FILL;
                        default:   n_state = ST_READ;
                    endcase
                end
            end
            ST_COPY: begin
                if (r_cnt == CNT_W'(CELLS) && r_pend) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result word
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_dst       = r_dst;
        n_pend      = 1'b0;
        n_emit      = r_emit;
        n_scroll    = r_scroll;
        n_fill_attr = r_fill_attr;
        n_o_valid   = 1'b0;
        n_o_pos     = r_o_pos;
        n_o_char    = r_o_char;
        n_o_attr    = r_o_attr;
        n_o_scr     = r_o_scr;
        char_we     = 1'b0;
        attr_we     = 1'b0;
        char_waddr  = cur_idx;
        attr_waddr  = cur_idx;
        char_wdata  = i_char_code;
        attr_wdata  = r_attr;
        raddr       = req_idx;
        case (r_state)
            ST_FILL: begin
                // Blank one cell per cycle; announce the result at the end, except after reset
                char_we    = 1'b1;
                attr_we    = 1'b1;
                char_waddr = r_cnt[ADDR_W-1:0];
                attr_waddr = r_cnt[ADDR_W-1:0];
                char_wdata = CHAR_BLANK;
                attr_wdata = r_fill_attr;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_o_valid = r_emit;
                    n_o_pos   = POS_W'(cur_idx);
                    n_o_char  = '0;
                    n_o_attr  = '0;
                    n_o_scr   = r_scroll;
                end
            end
            ST_IDLE: begin
                n_emit   = 1'b1;
                n_scroll = 1'b0;
                if (accept) begin
                    case (act)
                        ACT_PUT: begin
                            n_col = put_col;
                            n_row = put_row;
                            if (i_char_code == CHAR_BS) begin
                                // Blank the character under the new cursor only
                                char_we    = 1'b1;
                                char_waddr = put_idx;
                                char_wdata = CHAR_BLANK;
                            end else if (i_char_code != CHAR_NL &&
                                         i_char_code != CHAR_TAB) begin
                                char_we = 1'b1;
                                attr_we = 1'b1;
                            end
                            if (put_wrap) begin
                                n_cnt    = CNT_W'(COLUMNS_N);
                                n_scroll = 1'b1;
                            end
                        end
                        ACT_SET: begin
                            n_col = sat_col;
                            n_row = sat_row;
                        end
                        ACT_CLEAR: begin
                            n_cnt       = '0;
                            n_fill_attr = r_attr;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // Read one row ahead, write the word read last cycle
                raddr      = r_cnt[ADDR_W-1:0];
                char_waddr = r_dst;
                attr_waddr = r_dst;
                char_wdata = char_rdata;
                attr_wdata = attr_rdata;
                char_we    = r_pend;
                attr_we    = r_pend;
                if (r_cnt != CNT_W'(CELLS)) begin
                    n_pend = 1'b1;
                    n_dst  = ADDR_W'(r_cnt - CNT_W'(COLUMNS_N));
                    n_cnt  = r_cnt + 1'b1;
                end else if (r_pend) begin
                    n_cnt       = CNT_W'(KEEP);
                    n_fill_attr = ATTR_BLANK;
                end
            end
            ST_READ: begin
                n_o_valid = 1'b1;
                n_o_pos   = POS_W'(cur_idx);
                n_o_char  = char_rdata;
                n_o_attr  = attr_rdata;
                n_o_scr   = 1'b0;
            end
            default: begin
                n_o_valid = 1'b1;
                n_o_pos   = POS_W'(cur_idx);
                n_o_char  = '0;
                n_o_attr  = '0;
                n_o_scr   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= ATTR_RESET;
            r_prot      <= PROT_RESET;
            r_cnt       <= '0;
            r_dst       <= '0;
            r_pend      <= 1'b0;
            r_emit      <= 1'b0;
            r_scroll    <= 1'b0;
            r_fill_attr <= ATTR_BLANK;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_dst       <= n_dst;
            r_pend      <= n_pend;
            r_emit      <= n_emit;
            r_scroll    <= n_scroll;
            r_fill_attr <= n_fill_attr;
            r_o_valid   <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ATTR: r_attr <= i_cfg_data;
                    default:  r_prot <= i_cfg_data[ROWF_W-1:0];
                endcase
            end
        end
    end

    // Result payload: held between strobes, no reset needed
    always_ff @(posedge i_clk) begin
        r_o_pos  <= n_o_pos;
        r_o_char <= n_o_char;
        r_o_attr <= n_o_attr;
        r_o_scr  <= n_o_scr;
    end

    assign o_valid           = r_o_valid;
    assign o_cursor_position = r_o_pos;
    assign o_cell_char       = r_o_char;
    assign o_cell_attribute  = r_o_attr;
    assign o_scrolled        = r_o_scr;

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (char_wdata),
        .i_raddr (raddr),
        .o_rdata (char_rdata)
    );

    tcw_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (attr_waddr),
        .i_wdata (attr_wdata),
        .i_raddr (raddr),
        .o_rdata (attr_rdata)
    );

endmodule
